FILE: hw/rtl/point_polygon_distance_assert.svh
// Assertion macros for the point-to-polygon distance block.
`ifndef POINT_POLYGON_DISTANCE_ASSERT_SVH
`define POINT_POLYGON_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("point_polygon_distance: check failed");

// Next-cycle implication, disabled during reset.
`define PPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("point_polygon_distance: check failed");

`endif

FILE: hw/rtl/ppd_pkg.sv
`timescale 1ns / 1ps
package ppd_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    // Wide signed width for sums, projections and differences.
    localparam int WIDE_W = PROD_W + 2;
    localparam int SQ_W   = 64;
    localparam int DIST_W = 33;
    localparam int MAG_W  = 32;
    localparam int ROOT_STEPS = SQ_W / 2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_AX,
        OP_CALC_V,
        OP_MUL_PROJ,
        OP_CALC_XY,
        OP_SQ_PROJ,
        OP_UPDATE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_EMIT
    } ppd_op_t;

endpackage

FILE: hw/rtl/ppd_ctrl.sv
`timescale 1ns / 1ps
module ppd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              sqrt_last,
    output ppd_pkg::ppd_op_t  op
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AX,
        ST_CALC_V,
        ST_MUL_PROJ,
        ST_CALC_XY,
        ST_SQ_PROJ,
        ST_UPDATE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   last_reg;
    logic   m_tvalid_reg;
    logic   emit_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign emit_ok  = !m_tvalid_reg || m_tready;

    always_comb begin
        case (state_reg)
            ST_IDLE:      op = s_tvalid ? ppd_pkg::OP_LOAD : ppd_pkg::OP_NONE;
            ST_MUL_AX:    op = ppd_pkg::OP_MUL_AX;
            ST_CALC_V:    op = ppd_pkg::OP_CALC_V;
            ST_MUL_PROJ:  op = ppd_pkg::OP_MUL_PROJ;
            ST_CALC_XY:   op = ppd_pkg::OP_CALC_XY;
            ST_SQ_PROJ:   op = ppd_pkg::OP_SQ_PROJ;
            ST_UPDATE:    op = ppd_pkg::OP_UPDATE;
            ST_SQRT_INIT: op = ppd_pkg::OP_SQRT_INIT;
            ST_SQRT:      op = ppd_pkg::OP_SQRT_STEP;
            ST_EMIT:      op = emit_ok ? ppd_pkg::OP_EMIT : ppd_pkg::OP_NONE;
            default:      op = ppd_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_EMIT && emit_ok) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        last_reg  <= s_tlast;
                        state_reg <= ST_MUL_AX;
                    end
                end
                ST_MUL_AX:    state_reg <= ST_CALC_V;
                ST_CALC_V:    state_reg <= ST_MUL_PROJ;
                ST_MUL_PROJ:  state_reg <= ST_CALC_XY;
                ST_CALC_XY:   state_reg <= ST_SQ_PROJ;
                ST_SQ_PROJ:   state_reg <= ST_UPDATE;
                ST_UPDATE:    state_reg <= last_reg ? ST_SQRT_INIT : ST_IDLE;
                ST_SQRT_INIT: state_reg <= ST_SQRT;
                ST_SQRT: begin
                    if (sqrt_last) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold until the output register is free
                    if (emit_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/ppd_datapath.sv
`timescale 1ns / 1ps
module ppd_datapath #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppd_pkg::ppd_op_t                    op,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       edge_start_x,
    input  logic signed [COORD_WIDTH-1:0]       edge_start_y,
    input  logic signed [COORD_WIDTH-1:0]       edge_end_x,
    input  logic signed [COORD_WIDTH-1:0]       edge_end_y,
    input  logic signed [COORD_WIDTH-1:0]       coef_a,
    input  logic signed [COORD_WIDTH-1:0]       coef_b,
    input  logic signed [COORD_WIDTH-1:0]       coef_c,
    input  logic signed [COORD_WIDTH-1:0]       coef_a_norm,
    input  logic signed [COORD_WIDTH-1:0]       coef_b_norm,
    output logic                                sqrt_last,
    output logic [ppd_pkg::DIST_W-1:0]          distance,
    output logic                                from_projection
);

    localparam int MUL_W  = ppd_pkg::MUL_W;
    localparam int PROD_W = ppd_pkg::PROD_W;
    localparam int WIDE_W = ppd_pkg::WIDE_W;
    localparam int SQ_W   = ppd_pkg::SQ_W;
    localparam int MAG_W  = ppd_pkg::MAG_W;
    localparam logic signed [WIDE_W-1:0] V_MAX =
        (WIDE_W'(1) <<< (COORD_WIDTH - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] V_MIN = -V_MAX - WIDE_W'(1);
    localparam logic [SQ_W-1:0] SQ_ONES = '1;
    localparam logic [SQ_W-1:0] ROOT_BIT0 = SQ_W'(1) << (SQ_W - 2);

    function automatic logic [WIDE_W-1:0] abs_w(input logic signed [WIDE_W-1:0] d);
        return d[WIDE_W-1] ? unsigned'(-d) : unsigned'(d);
    endfunction

    function automatic logic [SQ_W-1:0] add_sat(input logic [SQ_W-1:0] a,
                                                input logic [SQ_W-1:0] b);
        logic [SQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SQ_W] ? SQ_ONES : s[SQ_W-1:0];
    endfunction

    function automatic logic between(input logic signed [WIDE_W-1:0] p,
                                     input logic signed [WIDE_W-1:0] a,
                                     input logic signed [WIDE_W-1:0] b);
        return (p >= a && p <= b) || (p >= b && p <= a);
    endfunction

    // captured item
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [COORD_WIDTH-1:0] a_reg, b_reg, c_reg, an_reg, bn_reg;

    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic signed [COORD_WIDTH-1:0] v_reg;
    logic vsat0_reg, vsat1_reg, psat0_reg, psat1_reg, inside_reg;
    logic [MAG_W-1:0] pmag0_reg, pmag1_reg;
    logic [SQ_W-1:0] dvert_reg;
    logic [SQ_W-1:0] best_reg, best_next;
    logic best_proj_reg, best_proj_next;
    logic [SQ_W-1:0] root_n_reg, root_r_reg, root_bit_reg;
    logic [ppd_pkg::DIST_W-1:0] dist_reg;
    logic from_proj_reg;

    logic signed [MUL_W-1:0] m0a, m0b, m1a, m1b;
    logic signed [PROD_W-1:0] prod0, prod1;

    logic signed [WIDE_W-1:0] xw, yw, sxw, syw, exw, eyw;
    logic [WIDE_W-1:0] vmag0, vmag1, dmag0, dmag1;
    logic signed [WIDE_W-1:0] v_sum, v_sat, xp, yp;
    logic [SQ_W-1:0] sq0, sq1, dproj, best_v;
    logic best_v_proj;
    logic [SQ_W-1:0] root_try;

    assign xw  = WIDE_W'(x_reg);
    assign yw  = WIDE_W'(y_reg);
    assign sxw = WIDE_W'(sx_reg);
    assign syw = WIDE_W'(sy_reg);
    assign exw = WIDE_W'(ex_reg);
    assign eyw = WIDE_W'(ey_reg);

    // vertex differences
    assign vmag0 = abs_w(sxw - xw);
    assign vmag1 = abs_w(syw - yw);

    // v = A*x + B*y + C, each product floored, then clamped to the coordinate range
    assign v_sum = WIDE_W'(p0_reg >>> FRAC_BITS) + WIDE_W'(p1_reg >>> FRAC_BITS)
                 + WIDE_W'(c_reg);
    assign v_sat = (v_sum > V_MAX) ? V_MAX : ((v_sum < V_MIN) ? V_MIN : v_sum);

    assign xp = (b_reg == '0) ? sxw : xw - WIDE_W'(p0_reg >>> FRAC_BITS);
    assign yp = (a_reg == '0) ? syw : yw - WIDE_W'(p1_reg >>> FRAC_BITS);
    assign dmag0 = abs_w(xp - xw);
    assign dmag1 = abs_w(yp - yw);

    // operand select for the two shared multipliers
    always_comb begin
        case (op)
            ppd_pkg::OP_MUL_AX: begin
                m0a = MUL_W'(a_reg);
                m0b = MUL_W'(x_reg);
                m1a = MUL_W'(b_reg);
                m1b = MUL_W'(y_reg);
            end
            ppd_pkg::OP_CALC_V: begin
                m0a = $signed({1'b0, vmag0[MAG_W-1:0]});
                m0b = m0a;
                m1a = $signed({1'b0, vmag1[MAG_W-1:0]});
                m1b = m1a;
            end
            ppd_pkg::OP_MUL_PROJ: begin
                m0a = MUL_W'(an_reg);
                m0b = MUL_W'(v_reg);
                m1a = MUL_W'(bn_reg);
                m1b = MUL_W'(v_reg);
            end
            ppd_pkg::OP_SQ_PROJ: begin
                m0a = $signed({1'b0, pmag0_reg});
                m0b = m0a;
                m1a = $signed({1'b0, pmag1_reg});
                m1b = m1a;
            end
            default: begin
                m0a = '0;
                m0b = '0;
                m1a = '0;
                m1b = '0;
            end
        endcase
    end

    assign prod0 = m0a * m0b;
    assign prod1 = m1a * m1b;

    // squares in p0/p1, saturated where the magnitude overflowed
    assign sq0 = (op == ppd_pkg::OP_UPDATE ? psat0_reg : vsat0_reg) ? SQ_ONES
               : unsigned'(p0_reg[SQ_W-1:0]);
    assign sq1 = (op == ppd_pkg::OP_UPDATE ? psat1_reg : vsat1_reg) ? SQ_ONES
               : unsigned'(p1_reg[SQ_W-1:0]);
    assign dproj = add_sat(sq0, sq1);

    // vertex must be strictly smaller; a projection wins ties
    always_comb begin
        if (dvert_reg < best_reg) begin
            best_v      = dvert_reg;
            best_v_proj = 1'b0;
        end else begin
            best_v      = best_reg;
            best_v_proj = best_proj_reg;
        end
        if (inside_reg && dproj <= best_v) begin
            best_next      = dproj;
            best_proj_next = 1'b1;
        end else begin
            best_next      = best_v;
            best_proj_next = best_v_proj;
        end
    end

    assign root_try  = root_r_reg + root_bit_reg;
    assign sqrt_last = root_bit_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg      <= SQ_ONES;
            best_proj_reg <= 1'b0;
        end else begin
            case (op)
                ppd_pkg::OP_UPDATE: begin
                    best_reg      <= best_next;
                    best_proj_reg <= best_proj_next;
                end
                ppd_pkg::OP_EMIT: begin
                    // start a new polygon once the result is captured
                    best_reg      <= SQ_ONES;
                    best_proj_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            ppd_pkg::OP_LOAD: begin
                x_reg  <= point_x;
                y_reg  <= point_y;
                sx_reg <= edge_start_x;
                sy_reg <= edge_start_y;
                ex_reg <= edge_end_x;
                ey_reg <= edge_end_y;
                a_reg  <= coef_a;
                b_reg  <= coef_b;
                c_reg  <= coef_c;
                an_reg <= coef_a_norm;
                bn_reg <= coef_b_norm;
            end
            ppd_pkg::OP_MUL_AX: begin
                p0_reg <= prod0;
                p1_reg <= prod1;
            end
            ppd_pkg::OP_CALC_V: begin
                v_reg     <= COORD_WIDTH'(v_sat);
                vsat0_reg <= vmag0[WIDE_W-1:MAG_W] != '0;
                vsat1_reg <= vmag1[WIDE_W-1:MAG_W] != '0;
                p0_reg    <= prod0;
                p1_reg    <= prod1;
            end
            ppd_pkg::OP_MUL_PROJ: begin
                dvert_reg <= add_sat(sq0, sq1);
                p0_reg    <= prod0;
                p1_reg    <= prod1;
            end
            ppd_pkg::OP_CALC_XY: begin
                inside_reg <= between(xp, sxw, exw) && between(yp, syw, eyw);
                pmag0_reg  <= dmag0[MAG_W-1:0];
                pmag1_reg  <= dmag1[MAG_W-1:0];
                psat0_reg  <= dmag0[WIDE_W-1:MAG_W] != '0;
                psat1_reg  <= dmag1[WIDE_W-1:MAG_W] != '0;
            end
            ppd_pkg::OP_SQ_PROJ: begin
                p0_reg <= prod0;
                p1_reg <= prod1;
            end
            ppd_pkg::OP_SQRT_INIT: begin
                root_n_reg   <= best_reg;
                root_r_reg   <= '0;
                root_bit_reg <= ROOT_BIT0;
            end
            ppd_pkg::OP_SQRT_STEP: begin
                // one result bit per step
                if (root_n_reg >= root_try) begin
                    root_n_reg <= root_n_reg - root_try;
                    root_r_reg <= (root_r_reg >> 1) + root_bit_reg;
                end else begin
                    root_r_reg <= root_r_reg >> 1;
                end
                root_bit_reg <= root_bit_reg >> 2;
            end
            ppd_pkg::OP_EMIT: begin
                dist_reg      <= root_r_reg[ppd_pkg::DIST_W-1:0];
                from_proj_reg <= best_proj_reg;
            end
            default: ;
        endcase
    end

    assign distance        = dist_reg;
    assign from_projection = from_proj_reg;

endmodule

FILE: hw/rtl/point_polygon_distance.sv
`timescale 1ns / 1ps
// Each edge item is accepted, then runs six steps over two shared multipliers before the next is taken.
// Last edge: the six steps are followed by a square-root set-up step, the bit-serial square root,
// one result bit per cycle, and an emit step that waits while the output register is still held.
// The next polygon's first edge may be taken while the result waits in its output register.
// Reset: aresetn synchronous, active low; clears the running minimum and all handshake state.
module point_polygon_distance #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // point_x, point_y, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
    // coef_a, coef_b, coef_c, coef_a_norm, coef_b_norm
    input  logic [((11*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // distance
    output logic [39:0]                  m_tdata,
    // from_projection
    output logic                         m_tuser
);

    localparam int CW = COORD_WIDTH;

    ppd_pkg::ppd_op_t op;
    logic sqrt_last;
    logic [ppd_pkg::DIST_W-1:0] distance;
    logic from_projection;

    ppd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tlast   (s_tlast),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sqrt_last (sqrt_last),
        .op        (op)
    );

    ppd_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .point_x         (s_tdata[0*CW +: CW]),
        .point_y         (s_tdata[1*CW +: CW]),
        .edge_start_x    (s_tdata[2*CW +: CW]),
        .edge_start_y    (s_tdata[3*CW +: CW]),
        .edge_end_x      (s_tdata[4*CW +: CW]),
        .edge_end_y      (s_tdata[5*CW +: CW]),
        .coef_a          (s_tdata[6*CW +: CW]),
        .coef_b          (s_tdata[7*CW +: CW]),
        .coef_c          (s_tdata[8*CW +: CW]),
        .coef_a_norm     (s_tdata[9*CW +: CW]),
        .coef_b_norm     (s_tdata[10*CW +: CW]),
        .sqrt_last       (sqrt_last),
        .distance        (distance),
        .from_projection (from_projection)
    );

    assign m_tdata = {(40 - ppd_pkg::DIST_W)'(0), distance};
    assign m_tuser = from_projection;

`include "point_polygon_distance_assert.svh"

    `PPD_ASSERT_NEXT(a_load_starts_mul, aclk, aresetn, s_tvalid && s_tready, op == ppd_pkg::OP_MUL_AX)
    `PPD_ASSERT_NEXT(a_emit_sets_valid, aclk, aresetn, op == ppd_pkg::OP_EMIT, m_tvalid)
    `PPD_ASSERT_NOW(a_valid_from_emit, aclk, aresetn, $rose(m_tvalid), $past(op) == ppd_pkg::OP_EMIT)
    `PPD_ASSERT_NOW(a_idle_no_op, aclk, aresetn, s_tready && !s_tvalid, op == ppd_pkg::OP_NONE)

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int CW      = 32;
    localparam int TD_W    = ((11*CW+7)/8)*8;
    localparam int LIMIT   = 1000000;
    localparam int N_ITEMS = 1750;

    typedef struct packed {
        logic signed [31:0] px, py, sx, sy, ex, ey, ca, cb, cc, can, cbn;
        logic               last;
    } edge_item_t;

    typedef struct packed {
        logic [32:0] dval;
        logic        proj;
    } dist_result_t;

    typedef struct {
        edge_item_t  e;
        bit          typed;
        logic [32:0] dval;
        logic        proj;
    } drow_t;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [TD_W-1:0]   s_tdata = '0;
    logic              s_tlast = 0;
    logic              m_tvalid;
    logic              m_tready = 1;
    logic [39:0]       m_tdata;
    logic              m_tuser;

    dist_result_t pending_dist[$];
    bit [63:0]    min_sq = '1;
    bit           min_is_proj = 0;
    int           fails = 0;
    int           cycles = 0;
    int           stall_left = 0;
    bit           stim_done = 0;

    point_polygon_distance #(.COORD_WIDTH(32), .FRAC_BITS(16)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    function automatic longint fshift(longint v);
        return v >>> 16;
    endfunction

    function automatic bit [63:0] sq_clip(longint d);
        bit [63:0] m;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (m > 64'hFFFF_FFFF) return '1;
        return m * m;
    endfunction

    function automatic bit [63:0] add_clip(bit [63:0] a, bit [63:0] b);
        bit [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic bit [32:0] root_floor(bit [63:0] n);
        bit [63:0] r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r[32:0];
    endfunction

    function automatic bit in_span(longint p, longint a, longint b);
        return (p >= a && p <= b) || (p >= b && p <= a);
    endfunction

    // Fold one edge into the running minimum; return 1 with the distance on the last edge.
    function automatic bit fold_edge(edge_item_t e, output dist_result_t r);
        longint x, y, sx, sy, v, xp, yp;
        bit [63:0] dv, dp;
        x = e.px; y = e.py; sx = e.sx; sy = e.sy;
        v = fshift(longint'(e.ca) * x) + fshift(longint'(e.cb) * y) + longint'(e.cc);
        if (v > 64'sd2147483647) v = 2147483647;
        if (v < -64'sd2147483648) v = -2147483648;
        xp = (e.cb == 0) ? sx : x - fshift(longint'(e.can) * v);
        yp = (e.ca == 0) ? sy : y - fshift(longint'(e.cbn) * v);
        dv = add_clip(sq_clip(sx - x), sq_clip(sy - y));
        if (dv < min_sq) begin
            min_sq = dv;
            min_is_proj = 0;
        end
        if (in_span(xp, sx, e.ex) && in_span(yp, sy, e.ey)) begin
            dp = add_clip(sq_clip(xp - x), sq_clip(yp - y));
            if (dp <= min_sq) begin
                min_sq = dp;
                min_is_proj = 1;
            end
        end
        r.dval = root_floor(min_sq);
        r.proj = min_is_proj;
        if (!e.last) return 0;
        min_sq = '1;
        min_is_proj = 0;
        return 1;
    endfunction

    task automatic send_edge(edge_item_t e, bit typed, logic [32:0] td, logic tp, bit calm);
        int gap;
        dist_result_t r;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tlast  <= e.last;
        s_tdata  <= {e.cbn, e.can, e.cc, e.cb, e.ca, e.ey, e.ex, e.sy, e.sx, e.py, e.px};
        do @(posedge aclk); while (!s_tready);
        if (fold_edge(e, r)) begin
            if (typed) begin
                r.dval = td;
                r.proj = tp;
            end
            pending_dist.push_back(r);
        end
    endtask

    function automatic edge_item_t mk(int px, int py, int sx, int sy, int ex, int ey,
                                      int a, int b, int c, int an, int bn, bit last);
        edge_item_t e;
        e = '{px, py, sx, sy, ex, ey, a, b, c, an, bn, last};
        return e;
    endfunction

    // Line through two vertices, coefficients in Q16.16.
    function automatic edge_item_t line_edge(int px, int py, int sx, int sy, int ex, int ey,
                                             bit last);
        real ar, br, cr, den;
        int a, b;
        a = ey - sy;
        b = sx - ex;
        ar = a / 65536.0;
        br = b / 65536.0;
        cr = -(ar * (sx / 65536.0) + br * (sy / 65536.0));
        den = ar * ar + br * br;
        if (den == 0.0) return mk(px, py, sx, sy, ex, ey, 0, 0, $rtoi(cr * 65536.0), 0, 0, last);
        return mk(px, py, sx, sy, ex, ey, a, b, $rtoi(cr * 65536.0),
                  $rtoi(ar / den * 65536.0), $rtoi(br / den * 65536.0), last);
    endfunction

    // Redraw the stall on every accepted result.
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_tready <= 1;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            stall_left <= gap;
            if (gap != 0) m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        dist_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dist.size() == 0) begin
                $display("%0t: unexpected result dist=%0d proj=%0b", $time, m_tdata[32:0], m_tuser);
                fails++;
            end else begin
                want = pending_dist.pop_front();
                if (m_tdata[32:0] !== want.dval || m_tuser !== want.proj) begin
                    $display("%0t: expected dist=%0d proj=%0b, got dist=%0d proj=%0b",
                             $time, want.dval, want.proj, m_tdata[32:0], m_tuser);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        drow_t rows[$];
        drow_t d;
        int items, n, vx[8], vy[8], px, py;
        bit calm, noisy;
        edge_item_t e;

        // Point on origin, vertex at (3,4): distance 5, projection ties the vertex.
        d = '{mk(0, 0, 3 << 16, 4 << 16, 3 << 16, 4 << 16, 0, 0, 0, 0, 0, 1), 1,
              33'd327680, 1'b1};
        rows.push_back(d);
        // Extreme corners: saturated square sum.
        d = '{mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1), 1, 33'd4294967295, 1'b1};
        rows.push_back(d);
        d = '{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                 0, 0, 0, 0, 0, 1), 1, 33'd4294967295, 1'b1};
        rows.push_back(d);
        // Saturating v, both signs.
        d = '{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1),
              0, 0, 0};
        rows.push_back(d);
        d = '{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1),
              0, 0, 0};
        rows.push_back(d);
        // Square polygon around the point: inside projections, one of each axis case.
        d = '{line_edge(1 << 16, 1 << 16, 0, 0, 4 << 16, 0, 0), 0, 0, 0};
        rows.push_back(d);
        d = '{line_edge(1 << 16, 1 << 16, 4 << 16, 0, 4 << 16, 4 << 16, 0), 0, 0, 0};
        rows.push_back(d);
        d = '{line_edge(1 << 16, 1 << 16, 4 << 16, 4 << 16, 0, 4 << 16, 0), 0, 0, 0};
        rows.push_back(d);
        d = '{line_edge(1 << 16, 1 << 16, 0, 4 << 16, 0, 0, 1), 0, 0, 0};
        rows.push_back(d);
        // Diagonal edge: projection outside the box, then inside.
        d = '{line_edge(-(5 << 16), 3 << 16, 0, 0, 2 << 16, 2 << 16, 0), 0, 0, 0};
        rows.push_back(d);
        d = '{line_edge(1 << 16, 0, 0, 0, 2 << 16, 2 << 16, 1), 0, 0, 0};
        rows.push_back(d);
        // Point on the start vertex and on the line, then a tie at zero.
        d = '{line_edge(3 << 16, 3 << 16, 3 << 16, 3 << 16, 9 << 16, 1 << 16, 0), 0, 0, 0};
        rows.push_back(d);
        d = '{line_edge(2 << 16, 2 << 16, 0, 0, 4 << 16, 4 << 16, 1), 0, 0, 0};
        rows.push_back(d);
        d = '{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1), 0, 0, 0};
        rows.push_back(d);

        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) send_edge(rows[i].e, rows[i].typed, rows[i].dval, rows[i].proj, 0);

        items = 0;
        while (items < N_ITEMS) begin
            n = $urandom_range(1, 8);
            calm = $urandom_range(0, 4) == 0;
            noisy = $urandom_range(0, 6) == 0;
            for (int k = 0; k < n; k++) begin
                vx[k] = ($urandom_range(0, 512) - 256) * 4096;
                vy[k] = ($urandom_range(0, 512) - 256) * 4096;
                if ($urandom_range(0, 5) == 0 && k > 0) vx[k] = vx[k-1];
                else if ($urandom_range(0, 5) == 0 && k > 0) vy[k] = vy[k-1];
            end
            if ($urandom_range(0, 9) == 0) begin
                px = $urandom;
                py = $urandom;
            end else begin
                px = ($urandom_range(0, 640) - 320) * 4096 + $urandom_range(0, 4095);
                py = ($urandom_range(0, 640) - 320) * 4096 + $urandom_range(0, 4095);
            end
            for (int k = 0; k < n; k++) begin
                if (noisy)
                    e = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom, k == n - 1);
                else begin
                    e = line_edge(px, py, vx[k], vy[k], vx[(k+1)%n], vy[(k+1)%n], k == n - 1);
                    // Corrupt a coefficient now and then.
                    if ($urandom_range(0, 9) == 0) e.cc = $urandom;
                    if ($urandom_range(0, 19) == 0) e.can = $urandom;
                end
                send_edge(e, 0, 0, 0, calm);
                items++;
            end
        end
        s_tvalid <= 0;
        stim_done = 1;

        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_ctrl.sv
hw/rtl/ppd_datapath.sv
hw/rtl/point_polygon_distance.sv
bench/testbench.sv
